### hw/rtl/kvct_pkg.sv
package kvct_pkg;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SEARCH,
        OP_INDEX
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_KEY_ZERO  = 2'd3;

    localparam logic [31:0] INDEX_LOW  = 32'd2;
    localparam logic [31:0] INDEX_HIGH = 32'h0000ffff;

    localparam int PRESET_COUNT = 4;

    // token handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        done;
        logic        appended;
        logic [31:0] rdata;
    } token_t;

    function automatic logic [31:0] preset_key(input int pos);
        logic [31:0] k;
        case (pos)
            0:       k = 32'h4d694e54;
            1:       k = 32'h5f435055;
            2:       k = 32'h5f465055;
            3:       k = 32'h5f4d4348;
            default: k = 32'd0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] preset_value(input int pos);
        logic [31:0] v;
        case (pos)
            0:       v = 32'h00000200;
            1:       v = 32'd20;
            2:       v = 32'd0;
            3:       v = 32'h00060000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/key_value_cookie_table_core.sv
// Append-only key/value table held in a row of CAPACITY cells, one entry per cell,
// preloaded with four system pairs at reset. Each request walks a token down the
// whole row, one cell per cycle, and its result word is formed from the token that
// leaves the last cell (a refused key-zero write skips the row).
// One request is in flight at a time; req_stall is high until its result has
// been moved into the output register, which may still be waiting on rsp_stall.
module key_value_cookie_table_core #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [31:0] key,
    input  logic [31:0] write_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [31:0] read_value
);

    localparam int CW = $clog2(CAPACITY + 1);

    kvct_pkg::state_t state_reg, state_next;
    kvct_pkg::op_t    op_reg;
    logic [31:0]      key_reg;
    logic [31:0]      value_reg;
    logic [CW-1:0]    count_reg;
    logic             start_reg;
    logic [1:0]       pend_status_reg;
    logic [31:0]      pend_data_reg;
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [31:0]      read_value_reg;

    kvct_pkg::token_t token_chain [0:CAPACITY];
    kvct_pkg::token_t last_tok;

    logic          accept;
    logic          refused;
    logic          start;
    logic          out_free;
    logic          load_rsp;
    kvct_pkg::op_t op_in;
    logic [1:0]    res_status;
    logic [31:0]   res_data;

    assign accept   = req_valid && !req_stall;
    assign refused  = (req_type == 1'b0) && (key == 32'd0);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign last_tok = token_chain[CAPACITY];

    always_comb
    begin
        if (req_type == 1'b0)
            op_in = kvct_pkg::OP_WRITE;
        else if (key >= kvct_pkg::INDEX_LOW && key <= kvct_pkg::INDEX_HIGH)
            op_in = kvct_pkg::OP_INDEX;
        else
            op_in = kvct_pkg::OP_SEARCH;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvct_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = refused ? kvct_pkg::ST_HOLD : kvct_pkg::ST_RUN;
            end
            kvct_pkg::ST_RUN:
            begin
                if (last_tok.active)
                    state_next = kvct_pkg::ST_HOLD;
            end
            kvct_pkg::ST_HOLD:
            begin
                if (out_free)
                    state_next = kvct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kvct_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        req_stall = 1'b1;
        load_rsp  = 1'b0;
        unique case (state_reg)
            kvct_pkg::ST_IDLE: req_stall = 1'b0;
            kvct_pkg::ST_RUN:  req_stall = 1'b1;
            kvct_pkg::ST_HOLD: load_rsp  = out_free;
            default:           req_stall = 1'b1;
        endcase
    end

    assign start = accept && !refused;

    // token enters the row once the request registers hold the word
    always_comb
    begin
        token_chain[0]          = '0;
        token_chain[0].active   = start_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        kvct_cell #(
            .POS (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op_reg),
            .req_key   (key_reg),
            .req_value (value_reg),
            .token_in  (token_chain[i]),
            .token_out (token_chain[i+1])
        );
    end

    always_comb
    begin
        res_status = kvct_pkg::STATUS_OK;
        res_data   = 32'd0;
        case (op_reg)
            kvct_pkg::OP_WRITE:
            begin
                if (!last_tok.done)
                    res_status = kvct_pkg::STATUS_FULL;
            end
            kvct_pkg::OP_SEARCH:
            begin
                if (last_tok.done)
                    res_data = last_tok.rdata;
                else
                    res_status = kvct_pkg::STATUS_NOT_FOUND;
            end
            kvct_pkg::OP_INDEX:
            begin
                if (32'(count_reg) < key_reg)
                    res_status = kvct_pkg::STATUS_NOT_FOUND;
                else if (last_tok.done)
                    res_data = last_tok.rdata;
            end
            default:
            begin
                res_status = kvct_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvct_pkg::ST_IDLE;
            count_reg     <= CW'(kvct_pkg::PRESET_COUNT);
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start;
            if (state_reg == kvct_pkg::ST_RUN && last_tok.active && last_tok.appended)
                count_reg <= count_reg + CW'(1);
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_in;
            key_reg   <= key;
            value_reg <= write_value;
            if (refused)
            begin
                pend_status_reg <= kvct_pkg::STATUS_KEY_ZERO;
                pend_data_reg   <= 32'd0;
            end
        end
        if (state_reg == kvct_pkg::ST_RUN && last_tok.active)
        begin
            pend_status_reg <= res_status;
            pend_data_reg   <= res_data;
        end
        if (load_rsp)
        begin
            status_reg     <= pend_status_reg;
            read_value_reg <= pend_data_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count moved by other than one");

    a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        last_tok.active |-> (state_reg == kvct_pkg::ST_RUN))
        else $error("token left the chain outside of a run");

    a_hold_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kvct_pkg::ST_HOLD && out_free) |=> rsp_valid_reg)
        else $error("held result not presented");

endmodule

### hw/rtl/kvct_cell.sv
module kvct_cell #(
    parameter int POS = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  kvct_pkg::op_t    op,
    input  logic [31:0]      req_key,
    input  logic [31:0]      req_value,
    input  kvct_pkg::token_t token_in,
    output kvct_pkg::token_t token_out
);

    localparam logic [15:0] POS_IDX = 16'(POS);
    localparam logic        OCC_RST = (POS < kvct_pkg::PRESET_COUNT);

    logic             occ_reg, occ_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      value_reg, value_next;
    kvct_pkg::token_t token_reg, token_next;

    always_comb
    begin
        occ_next   = occ_reg;
        key_next   = key_reg;
        value_next = value_reg;
        token_next = token_in;
        if (token_in.active && !token_in.done)
        begin
            case (op)
                kvct_pkg::OP_WRITE:
                begin
                    if (occ_reg && key_reg == req_key)
                    begin
                        value_next      = req_value;
                        token_next.done = 1'b1;
                    end
                    else if (!occ_reg)
                    begin
                        occ_next            = 1'b1;
                        key_next            = req_key;
                        value_next          = req_value;
                        token_next.done     = 1'b1;
                        token_next.appended = 1'b1;
                    end
                end
                kvct_pkg::OP_SEARCH:
                begin
                    if (occ_reg && key_reg == req_key)
                    begin
                        token_next.rdata = value_reg;
                        token_next.done  = 1'b1;
                    end
                end
                kvct_pkg::OP_INDEX:
                begin
                    if (req_key[15:0] == POS_IDX)
                    begin
                        token_next.rdata = occ_reg ? key_reg : 32'd0;
                        token_next.done  = 1'b1;
                    end
                end
                default:
                begin
                    token_next = token_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= OCC_RST;
            key_reg   <= kvct_pkg::preset_key(POS);
            value_reg <= kvct_pkg::preset_value(POS);
            token_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            key_reg   <= key_next;
            value_reg <= value_next;
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule
